/* hdl/viridis_colormap_polynomial_defines.svh */
// assertion macros for the viridis colormap checker
// expects clk and arst_n in the scope of each use
`ifndef VIRIDIS_COLORMAP_POLYNOMIAL_DEFINES_SVH
`define VIRIDIS_COLORMAP_POLYNOMIAL_DEFINES_SVH

// same-cycle implication
`define VCM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication with a fixed delay
`define VCM_ASSERT_DLY(name, ante, dly, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

/* hdl/vcm_pkg.sv */
// shared types and constants for the viridis colormap pipeline
// no dependencies
package vcm_pkg;

	localparam int NUM_CH    = 3;
	localparam int NUM_COEF  = 5;
	localparam int ACC_W     = 26;
	localparam int COEF_FRAC = 20;
	localparam int BYTE_W    = 8;

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [BYTE_W-1:0]       byte_t;

	localparam byte_t BYTE_MAX = '1;

	// signed Q6.20 coefficients, highest power first
	localparam acc_t COEF [NUM_CH][NUM_COEF] = '{
		'{acc_t'(-4167246), acc_t'(10848384), acc_t'(-6870924), acc_t'(951307),
			acc_t'(279974)},
		'{acc_t'(-1430890), acc_t'(2704219), acc_t'(-2011936), acc_t'(1683672),
			acc_t'(5111)},
		'{acc_t'(904038), acc_t'(-994874), acc_t'(-1409409), acc_t'(1305756),
			acc_t'(345417)}
	};

endpackage

/* hdl/vcm_stage.sv */
// one registered horner step for all three channels
// depends on vcm_pkg
module vcm_stage import vcm_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int STEP      = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic [FRAC_BITS:0] in_x,
	input  acc_t               in_acc [NUM_CH],
	output logic               out_vld,
	output logic [FRAC_BITS:0] out_x,
	output acc_t               out_acc [NUM_CH]
);

	localparam int XW = FRAC_BITS + 1;
	localparam int PW = ACC_W + XW + 1;

	logic signed [PW-1:0] prod [NUM_CH];
	logic signed [PW-1:0] shf  [NUM_CH];
	acc_t                 nxt  [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			prod[c] = PW'(in_acc[c]) * $signed({1'b0, in_x});
			shf[c]  = prod[c] >>> FRAC_BITS;
			nxt[c]  = acc_t'(shf[c]) + COEF[c][STEP];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		out_x   <= in_x;
		out_acc <= nxt;
	end

endmodule

/* hdl/vcm_byte.sv */
// scales each channel by 255, truncates and saturates to a byte
// depends on vcm_pkg
module vcm_byte import vcm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_vld,
	input  acc_t  in_acc [NUM_CH],
	output logic  out_vld,
	output byte_t out_byte [NUM_CH]
);

	localparam int SW = ACC_W + BYTE_W;
	localparam int HW = SW - COEF_FRAC;

	logic signed [SW-1:0] s255 [NUM_CH];
	logic [HW-1:0]        hi   [NUM_CH];
	byte_t                nxt  [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			s255[c] = (SW'(in_acc[c]) <<< BYTE_W) - SW'(in_acc[c]);
			hi[c]   = s255[c][SW-1:COEF_FRAC];
			if (in_acc[c] <= acc_t'(0)) begin
				nxt[c] = '0;
			end else if (hi[c] > HW'(BYTE_MAX)) begin
				nxt[c] = BYTE_MAX;
			end else begin
				nxt[c] = hi[c][BYTE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		out_byte <= nxt;
	end

endmodule

/* hdl/viridis_colormap_polynomial.sv */
// top level of the viridis colormap polynomial pipeline
// depends on vcm_pkg, vcm_stage and vcm_byte
//
// Maps a level in [0,1] (unsigned, FRAC_BITS fraction bits, levels above 1.0
// clamp to 1.0) to red, green and blue bytes. A transaction is taken on every
// clock edge with start high; busy is always low, so one level per clock is
// sustained. The result shows on red/green/blue with done high for exactly one
// cycle, once the transaction has passed one clamp stage, four Horner stages
// (one multiply-add per channel each) and one scale-and-saturate stage. There
// is no backpressure: the receiver must take every result on its done cycle.
module viridis_colormap_polynomial import vcm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [FRAC_BITS:0] level,
	output logic               done,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);

	localparam int NUM_STEP = NUM_COEF - 1;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic               vld_s1;
	logic [FRAC_BITS:0] x_s1;
	acc_t               acc_init [NUM_CH];

	logic               vld_p [NUM_STEP+1];
	logic [FRAC_BITS:0] x_p   [NUM_STEP+1];
	acc_t               acc_p [NUM_STEP+1][NUM_CH];

	byte_t              rgb [NUM_CH];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= (level > ONE) ? ONE : level;
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			acc_init[c] = COEF[c][0];
		end
	end

	assign vld_p[0] = vld_s1;
	assign x_p[0]   = x_s1;
	assign acc_p[0] = acc_init;

	for (genvar k = 0; k < NUM_STEP; k++) begin : g_step
		vcm_stage #(
			.FRAC_BITS(FRAC_BITS),
			.STEP     (k + 1)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.in_vld (vld_p[k]),
			.in_x   (x_p[k]),
			.in_acc (acc_p[k]),
			.out_vld(vld_p[k+1]),
			.out_x  (x_p[k+1]),
			.out_acc(acc_p[k+1])
		);
	end

	vcm_byte u_byte (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_p[NUM_STEP]),
		.in_acc  (acc_p[NUM_STEP]),
		.out_vld (done),
		.out_byte(rgb)
	);

	assign red   = rgb[CH_RED];
	assign green = rgb[CH_GREEN];
	assign blue  = rgb[CH_BLUE];

endmodule

/* hdl/vcm_checker.sv */
// port-level checks for viridis_colormap_polynomial, bound to the top level
// depends on viridis_colormap_polynomial_defines.svh
`include "viridis_colormap_polynomial_defines.svh"

module vcm_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [FRAC_BITS:0] level,
	input logic               done,
	input logic [7:0]         red,
	input logic [7:0]         green,
	input logic [7:0]         blue
);

	`VCM_ASSERT_DLY(a_latency, start && !busy, 6, done, "result missing six cycles after transaction")

	`VCM_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, 6), "result without a transaction")

	`VCM_ASSERT_DLY(a_repeat, (start && !busy) ##1 (start && !busy && level == $past(level)), 6, done && $stable(red) && $stable(green) && $stable(blue), "equal levels gave different colors")

	`VCM_ASSERT_DLY(a_level_zero, start && !busy && level == '0, 6, red == 8'd68 && green == 8'd1 && blue == 8'd84, "wrong color at level zero")

endmodule

bind viridis_colormap_polynomial vcm_checker #(.FRAC_BITS(FRAC_BITS)) u_vcm_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.level (level),
	.done  (done),
	.red   (red),
	.green (green),
	.blue  (blue)
);
